/* design/ctkd_pkg.sv */
// Package: payload types, AES constants and round helper functions for the CTKD block.
`default_nettype none
package ctkd_pkg;

    typedef struct packed {
        logic [63:0] ltk_high;
        logic [63:0] ltk_low;
        logic        mode;
    } ctkd_in_t;

    typedef struct packed {
        logic [63:0] link_key_high;
        logic [63:0] link_key_low;
    } ctkd_out_t;

    // Number of AES rounds; a pipe adds one whitening stage in front
    localparam int unsigned AES_ROUNDS = 10;

    // Salt for h7: twelve zero bytes then "tmp1", block byte 0 in bits 127:120
    localparam logic [127:0] SALT_CT2 = 128'h0000_0000_0000_0000_0000_0000_746d_7031;
    // Padded "tmp1" and "lebr" blocks (message, 0x80, zeros)
    localparam logic [127:0] MSG_TMP1 = 128'h746d_7031_8000_0000_0000_0000_0000_0000;
    localparam logic [127:0] MSG_LEBR = 128'h6c65_6272_8000_0000_0000_0000_0000_0000;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [0:255];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block, byte 0 in bits 127:120
    function automatic logic [7:0] byte_at(input logic [127:0] b, input int unsigned i);
        return b[127 - 8 * i -: 8];
    endfunction

    // Next round key from the current one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = sbox(byte_at(s, i + 4 * ((c + i) % 4)));
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = t[i];
        end
        return o ^ rk;
    endfunction

    // Doubling in GF(2^128)
    function automatic logic [127:0] gf_double(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
    endfunction

endpackage
`default_nettype wire

/* design/ctkd_link_key_derivation.sv */
// Structure: 45 register stages, four 11-stage AES pipes plus the output register.
// Throughput: one derivation per cycle while no stalled result is held;
// the four AES-128 round pipelines set the depth.
// A stalled result freezes the whole pipeline and stalls the input in the same cycle.
// Reset: rst_n asynchronously clears all valid bits; data registers are not reset.
// The block holds no state between words.
`default_nettype none
module ctkd_link_key_derivation
    import ctkd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire ctkd_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output ctkd_out_t      out_data
);

    logic         out_valid_reg;
    ctkd_out_t    out_data_reg;
    logic         advance;
    logic [127:0] key_be;
    logic [127:0] key1_in;
    logic [127:0] blk1_in;

    // Pipe A: L1 = AES(K1, 0)
    logic         a_v;
    logic [127:0] a_blk, a_key_unused;
    logic [256:0] a_side;
    // Pipe B: mid = AES(K1, msg ^ K)
    logic         b_v;
    logic [127:0] b_blk, b_key_unused;
    logic [127:0] b_side_unused;
    // Pipe C: L2 = AES(mid, 0)
    logic         c_v;
    logic [127:0] c_blk, c_key_unused, c_side;
    // Pipe D: res = AES(mid, lebr ^ K2)
    logic         d_v;
    logic [127:0] d_blk, d_key_unused, d_side_unused;

    // Advance everything unless a held result is being stalled
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // The key as a block (byte 15 first) is the concatenation; pick key and block by mode
    always_comb begin
        key_be  = {in_data.ltk_high, in_data.ltk_low};
        key1_in = in_data.mode ? SALT_CT2 : key_be;
        blk1_in = in_data.mode ? key_be : MSG_TMP1;
    end

    ctkd_aes_pipe #(.SIDE_W(257)) u_pipe_a (
        .clk, .rst_n, .advance,
        .in_valid (in_valid),
        .in_key   (key1_in),
        .in_block ('0),
        .in_side  ({in_data.mode, key1_in, blk1_in}),
        .out_valid(a_v),
        .out_block(a_blk),
        .out_key  (a_key_unused),
        .out_side (a_side)
    );

    // Build the CMAC subkey-masked block: full block in mode 1, padded block in mode 0
    logic [127:0] a_k1, a_k2, b_blk_in;
    always_comb begin
        a_k1     = gf_double(a_blk);
        a_k2     = gf_double(a_k1);
        b_blk_in = a_side[256] ? a_side[127:0] ^ a_k1 : a_side[127:0] ^ a_k2;
    end

    ctkd_aes_pipe #(.SIDE_W(128)) u_pipe_b (
        .clk, .rst_n, .advance,
        .in_valid (a_v),
        .in_key   (a_side[128 +: 128]),
        .in_block (b_blk_in),
        .in_side  (a_side[128 +: 128]),
        .out_valid(b_v),
        .out_block(b_blk),
        .out_key  (b_key_unused),
        .out_side (b_side_unused)
    );

    ctkd_aes_pipe #(.SIDE_W(128)) u_pipe_c (
        .clk, .rst_n, .advance,
        .in_valid (b_v),
        .in_key   (b_blk),
        .in_block ('0),
        .in_side  (b_blk),
        .out_valid(c_v),
        .out_block(c_blk),
        .out_key  (c_key_unused),
        .out_side (c_side)
    );

    logic [127:0] d_blk_in;
    assign d_blk_in = MSG_LEBR ^ gf_double(gf_double(c_blk));

    ctkd_aes_pipe #(.SIDE_W(128)) u_pipe_d (
        .clk, .rst_n, .advance,
        .in_valid (c_v),
        .in_key   (c_side),
        .in_block (d_blk_in),
        .in_side  (c_side),
        .out_valid(d_v),
        .out_block(d_blk),
        .out_key  (d_key_unused),
        .out_side (d_side_unused)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= d_v;
        end
    end

    // Block byte 0 lands in the top byte of the link key
    always_ff @(posedge clk) begin
        if (advance) begin
            {out_data_reg.link_key_high, out_data_reg.link_key_low} <= d_blk;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* design/ctkd_aes_pipe.sv */
// Pipelined AES-128 encryption, one round per stage, with a side-band word carried along.
`default_nettype none
module ctkd_aes_pipe
    import ctkd_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               in_valid,
    input  wire logic [127:0]       in_key,
    input  wire logic [127:0]       in_block,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output logic [127:0]            out_block,
    output logic [127:0]            out_key,
    output logic [SIDE_W-1:0]       out_side
);

    logic              valid_reg [0:AES_ROUNDS];
    logic [127:0]      state_reg [0:AES_ROUNDS];
    logic [127:0]      key_reg   [0:AES_ROUNDS];
    logic [SIDE_W-1:0] side_reg  [0:AES_ROUNDS];

    // Advance valid bits through all stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i <= AES_ROUNDS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= AES_ROUNDS; i++) begin
                valid_reg[i] <= valid_reg[i - 1];
            end
        end
    end

    // Stage 0 whitens; stages 1..10 run a round each and step the key schedule
    always_ff @(posedge clk) begin
        if (advance) begin
            state_reg[0] <= in_block ^ in_key;
            key_reg[0]   <= in_key;
            side_reg[0]  <= in_side;
            for (int i = 1; i <= AES_ROUNDS; i++) begin
                key_reg[i]   <= key_step(key_reg[i - 1], 4'(i));
                state_reg[i] <= aes_round(state_reg[i - 1],
                                          key_step(key_reg[i - 1], 4'(i)),
                                          i == AES_ROUNDS);
                side_reg[i]  <= side_reg[i - 1];
            end
        end
    end

    assign out_valid = valid_reg[AES_ROUNDS];
    assign out_block = state_reg[AES_ROUNDS];
    // Round 10 key; the cipher key is recovered by the caller through side data
    assign out_key   = key_reg[AES_ROUNDS];
    assign out_side  = side_reg[AES_ROUNDS];

endmodule
`default_nettype wire

/* design/ctkd_checker.sv */
// Port-level checker for the CTKD block, bound to the top level.
`default_nettype none
module ctkd_checker
    import ctkd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire ctkd_in_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire ctkd_out_t out_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");

    // Input stalls only when the output is stalled with a word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // No result appears out of reset before any word could pass
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

endmodule

bind ctkd_link_key_derivation ctkd_checker u_ctkd_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
`default_nettype wire
